### rtl/rrv_pkg.sv
// Shared widths, fixed-point constants and word types of the reflect/refract vector block.
package rrv_pkg;

    localparam int FRAC_BITS = 20;              // fraction bits of every vector value
    localparam int IN_W      = 24;              // width of one vector component
    localparam int IDX_W     = 16;              // width of a refractive index
    localparam int FX_W      = 64;              // width of an intermediate value
    localparam int SAT_W     = 62;              // intermediates saturate to +-(2^SAT_W - 1)

    // Index ratio divider: numerator is outer << FRAC_BITS plus half the divisor
    localparam int NUM_W     = IDX_W + FRAC_BITS + 1;

    // Square root of t2 << FRAC_BITS, two radicand bits per cell
    localparam int RAD_W     = SAT_W + FRAC_BITS + (FRAC_BITS % 2);
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;

    localparam int MUL_LAT   = 5;               // register stages of one multiplier

    typedef logic signed [FX_W-1:0] t_fx;
    typedef logic signed [IN_W-1:0] t_comp;
    typedef t_comp [2:0]            t_vec;
    typedef t_fx   [2:0]            t_fx3;

    localparam t_fx SAT_LIM = t_fx'((64'd1 << SAT_W) - 64'd1);
    localparam t_fx ONE_FX  = t_fx'(64'd1 << FRAC_BITS);

    // What travels with an item through the divider row
    typedef struct packed {
        logic kind;
        logic izero;
        t_vec v;
        t_vec n;
    } t_side;

    // What travels with an item from the first multiplier group to the end
    typedef struct packed {
        logic kind;
        logic izero;
        logic tir;
        t_vec n;
        t_vec refl;
        t_fx3 rv;
        t_fx  kterm;
    } t_carry;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [IDX_W-1:0] den;
        logic [IDX_W-1:0] rem;
        logic [NUM_W-1:0] quo;
        t_side            side;
    } t_div;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        t_carry            side;
    } t_sqrt;

endpackage

### rtl/rrv_div_cell.sv
// One restoring-division cell: one quotient bit per clock while i_en is high.
module rrv_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  rrv_pkg::t_div i_word,
    output logic          o_valid,
    output rrv_pkg::t_div o_word
);

    logic                       r_valid;
    rrv_pkg::t_div              r_word;
    rrv_pkg::t_div              n_word;
    logic [rrv_pkg::IDX_W:0]    rem_sh;
    logic [rrv_pkg::IDX_W+1:0]  diff;
    logic                       take;

    always_comb begin
        rem_sh = {i_word.rem, i_word.num[rrv_pkg::NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, i_word.den};
        take   = !diff[rrv_pkg::IDX_W+1];
        n_word      = i_word;
        n_word.rem  = take ? diff[rrv_pkg::IDX_W-1:0] : rem_sh[rrv_pkg::IDX_W-1:0];
        n_word.num  = {i_word.num[rrv_pkg::NUM_W-2:0], 1'b0};
        n_word.quo  = {i_word.quo[rrv_pkg::NUM_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### rtl/rrv_sqrt_cell.sv
// One restoring square-root cell: one root bit per clock while i_en is high.
module rrv_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rrv_pkg::t_sqrt i_word,
    output logic           o_valid,
    output rrv_pkg::t_sqrt o_word
);

    logic                        r_valid;
    rrv_pkg::t_sqrt              r_word;
    rrv_pkg::t_sqrt              n_word;
    logic [rrv_pkg::REM_W+1:0]   rem_sh;
    logic [rrv_pkg::REM_W+1:0]   trial;
    logic [rrv_pkg::REM_W+2:0]   diff;
    logic                        take;

    always_comb begin
        rem_sh = {i_word.rem, i_word.rad[rrv_pkg::RAD_W-1 -: 2]};
        trial  = (rrv_pkg::REM_W+2)'({i_word.root, 2'b01});
        diff   = {1'b0, rem_sh} - {1'b0, trial};
        take   = !diff[rrv_pkg::REM_W+2];
        n_word      = i_word;
        n_word.rem  = take ? diff[rrv_pkg::REM_W-1:0] : rem_sh[rrv_pkg::REM_W-1:0];
        n_word.root = {i_word.root[rrv_pkg::ROOT_W-2:0], take};
        n_word.rad  = {i_word.rad[rrv_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### rtl/rrv_mul.sv
// Pipelined signed fixed-point multiply with rounding half away from zero and saturation.
module rrv_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  rrv_pkg::t_fx i_a,
    input  rrv_pkg::t_fx i_b,
    output rrv_pkg::t_fx o_p
);

    localparam int MAG_W  = rrv_pkg::FX_W - 1;
    localparam int LO_W   = 32;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int Q_W    = PROD_W - rrv_pkg::FRAC_BITS;

    rrv_pkg::t_fx                 a_abs;
    rrv_pkg::t_fx                 b_abs;
    logic [rrv_pkg::MUL_LAT-2:0]  r_neg;
    logic [MAG_W-1:0]             r_ma;
    logic [MAG_W-1:0]             r_mb;
    logic [2*LO_W-1:0]            r_pll;
    logic [LO_W+HI_W-1:0]         r_plh;
    logic [LO_W+HI_W-1:0]         r_phl;
    logic [2*HI_W-1:0]            r_phh;
    logic [LO_W+HI_W:0]           r_cross;
    logic [2*LO_W-1:0]            r_ll;
    logic [2*HI_W-1:0]            r_hh;
    logic [PROD_W-1:0]            r_prod;
    logic [PROD_W-1:0]            n_prod;
    logic [Q_W-1:0]               q;
    rrv_pkg::t_fx                 mq;
    rrv_pkg::t_fx                 r_p;

    always_comb begin
        a_abs  = i_a[rrv_pkg::FX_W-1] ? -i_a : i_a;
        b_abs  = i_b[rrv_pkg::FX_W-1] ? -i_b : i_b;
        n_prod = (PROD_W'(r_hh) << (2 * LO_W)) + (PROD_W'(r_cross) << LO_W)
               + PROD_W'(r_ll) + (PROD_W'(1) << (rrv_pkg::FRAC_BITS - 1));
        q      = r_prod[PROD_W-1:rrv_pkg::FRAC_BITS];
        mq     = (|q[Q_W-1:rrv_pkg::SAT_W]) ? rrv_pkg::SAT_LIM
                                             : rrv_pkg::t_fx'(q[rrv_pkg::SAT_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg   <= {r_neg[rrv_pkg::MUL_LAT-3:0],
                        i_a[rrv_pkg::FX_W-1] ^ i_b[rrv_pkg::FX_W-1]};
            r_ma    <= a_abs[MAG_W-1:0];
            r_mb    <= b_abs[MAG_W-1:0];
            r_pll   <= r_ma[LO_W-1:0] * r_mb[LO_W-1:0];
            r_plh   <= r_ma[LO_W-1:0] * r_mb[MAG_W-1:LO_W];
            r_phl   <= r_ma[MAG_W-1:LO_W] * r_mb[LO_W-1:0];
            r_phh   <= r_ma[MAG_W-1:LO_W] * r_mb[MAG_W-1:LO_W];
            r_cross <= (LO_W+HI_W+1)'(r_plh) + (LO_W+HI_W+1)'(r_phl);
            r_ll    <= r_pll;
            r_hh    <= r_phh;
            r_prod  <= n_prod;
            r_p     <= r_neg[rrv_pkg::MUL_LAT-2] ? -mq : mq;
        end
    end

    assign o_p = r_p;

endmodule

### rtl/reflect_refract_vector.sv
// Top level: mirror reflection and Snell refraction of a Q4.20 direction vector.
//
//  channel  handshake                  payload
//  -------  -------------------------  ---------------------------------------------
//  input    i_in_valid / o_in_ready    i_kind, i_in_x/y/z, i_norm_x/y/z, indices
//  output   o_out_valid / i_out_ready  o_out_x/y/z, o_total_internal
//
//  One word enters per clock while the pipeline is not held. The row of divider
//  cells for the index ratio and the row of square-root cells each give one
//  result bit per cell per clock.
//  Reset is synchronous, active low; it clears only the valid bits of the stages.
//  The whole pipeline holds only while a result waits at the output and another
//  sits in the last stage; otherwise a new word is taken every clock.
module reflect_refract_vector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic signed [23:0]          i_in_x,
    input  logic signed [23:0]          i_in_y,
    input  logic signed [23:0]          i_in_z,
    input  logic signed [23:0]          i_norm_x,
    input  logic signed [23:0]          i_norm_y,
    input  logic signed [23:0]          i_norm_z,
    input  logic [15:0]                 i_outer_index,
    input  logic [15:0]                 i_inner_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [23:0]          o_out_x,
    output logic signed [23:0]          o_out_y,
    output logic signed [23:0]          o_out_z,
    output logic                        o_total_internal
);

    localparam int DSUM_W = 2 * rrv_pkg::IN_W + 2;
    localparam int LAST   = rrv_pkg::MUL_LAT - 1;

    function automatic rrv_pkg::t_comp sat24(input rrv_pkg::t_fx x);
        rrv_pkg::t_fx hi;
        rrv_pkg::t_fx lo;
        hi = rrv_pkg::t_fx'((64'd1 << (rrv_pkg::IN_W - 1)) - 64'd1);
        lo = -hi - rrv_pkg::t_fx'(1);
        if (x > hi) begin
            return hi[rrv_pkg::IN_W-1:0];
        end else if (x < lo) begin
            return lo[rrv_pkg::IN_W-1:0];
        end else begin
            return x[rrv_pkg::IN_W-1:0];
        end
    endfunction

    logic en;

    // ---------------- divider row: ratio = round(outer << FRAC / inner)
    rrv_pkg::t_div div_w [rrv_pkg::NUM_W+1];
    logic          div_v [rrv_pkg::NUM_W+1];

    always_comb begin
        div_w[0].num        = (rrv_pkg::NUM_W'(i_outer_index) << rrv_pkg::FRAC_BITS)
                            + rrv_pkg::NUM_W'(i_inner_index >> 1);
        div_w[0].den        = i_inner_index;
        div_w[0].rem        = '0;
        div_w[0].quo        = '0;
        div_w[0].side.kind  = i_kind;
        div_w[0].side.izero = (i_inner_index == '0);
        div_w[0].side.v     = {i_in_z, i_in_y, i_in_x};
        div_w[0].side.n     = {i_norm_z, i_norm_y, i_norm_x};
        div_v[0]            = i_in_valid && en;
    end

    for (genvar g = 0; g < rrv_pkg::NUM_W; g++) begin : g_div
        rrv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_v[g]),
            .i_word  (div_w[g]),
            .o_valid (div_v[g+1]),
            .o_word  (div_w[g+1])
        );
    end

    // ---------------- dot product in.norm, rounded to FRAC bits
    logic                     r_d1_valid, r_d2_valid, r_d3_valid;
    rrv_pkg::t_side           r_d1_side, r_d2_side, r_d3_side;
    logic [rrv_pkg::NUM_W-1:0] r_d1_ratio, r_d2_ratio, r_d3_ratio;
    logic signed [2*rrv_pkg::IN_W-1:0] r_d1_prod [3];
    logic signed [DSUM_W-1:0] r_d2_sum;
    rrv_pkg::t_fx             r_d3_d;
    logic [DSUM_W-1:0]        dmag;
    logic [DSUM_W-1:0]        dround;
    rrv_pkg::t_fx             dval;

    always_comb begin
        dmag   = r_d2_sum[DSUM_W-1] ? DSUM_W'(-r_d2_sum) : DSUM_W'(r_d2_sum);
        dround = (dmag + (DSUM_W'(1) << (rrv_pkg::FRAC_BITS - 1))) >> rrv_pkg::FRAC_BITS;
        dval   = r_d2_sum[DSUM_W-1] ? -rrv_pkg::t_fx'(dround) : rrv_pkg::t_fx'(dround);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_valid <= 1'b0;
            r_d2_valid <= 1'b0;
            r_d3_valid <= 1'b0;
        end else if (en) begin
            r_d1_valid <= div_v[rrv_pkg::NUM_W];
            r_d2_valid <= r_d1_valid;
            r_d3_valid <= r_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_side  <= div_w[rrv_pkg::NUM_W].side;
            r_d1_ratio <= div_w[rrv_pkg::NUM_W].quo;
            for (int i = 0; i < 3; i++) begin
                r_d1_prod[i] <= $signed(div_w[rrv_pkg::NUM_W].side.v[i])
                              * $signed(div_w[rrv_pkg::NUM_W].side.n[i]);
            end
            r_d2_side  <= r_d1_side;
            r_d2_ratio <= r_d1_ratio;
            r_d2_sum   <= DSUM_W'(r_d1_prod[0]) + DSUM_W'(r_d1_prod[1])
                        + DSUM_W'(r_d1_prod[2]);
            r_d3_side  <= r_d2_side;
            r_d3_ratio <= r_d2_ratio;
            r_d3_d     <= dval;
        end
    end

    // ---------------- first multiplier group
    rrv_pkg::t_fx ratio_fx, cos_i, twod;
    rrv_pkg::t_fx m_cc, m_r2, m_rc;
    rrv_pkg::t_fx m_rv [3];
    rrv_pkg::t_fx m_rf [3];

    assign ratio_fx = rrv_pkg::t_fx'(r_d3_ratio);
    assign cos_i    = -r_d3_d;
    assign twod     = r_d3_d <<< 1;   // reflection term uses twice the dot product

    rrv_mul u_mul_cc (.i_clk(i_clk), .i_en(en), .i_a(cos_i),    .i_b(cos_i),    .o_p(m_cc));
    rrv_mul u_mul_r2 (.i_clk(i_clk), .i_en(en), .i_a(ratio_fx), .i_b(ratio_fx), .o_p(m_r2));
    rrv_mul u_mul_rc (.i_clk(i_clk), .i_en(en), .i_a(ratio_fx), .i_b(cos_i),    .o_p(m_rc));

    for (genvar c = 0; c < 3; c++) begin : g_m1
        rrv_mul u_mul_rv (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (ratio_fx),
            .i_b   (rrv_pkg::t_fx'($signed(r_d3_side.v[c]))),
            .o_p   (m_rv[c])
        );
        rrv_mul u_mul_rf (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (twod),
            .i_b   (rrv_pkg::t_fx'($signed(r_d3_side.n[c]))),
            .o_p   (m_rf[c])
        );
    end

    logic [LAST:0]  r_m1_valid;
    rrv_pkg::t_side r_m1_side [rrv_pkg::MUL_LAT];

    // ---------------- E1: 1 - cos_i^2, reflection result
    logic            r_e1_valid;
    rrv_pkg::t_carry r_e1_carry;
    rrv_pkg::t_carry n_e1_carry;
    rrv_pkg::t_fx    r_e1_r2;
    rrv_pkg::t_fx    r_e1_a;

    always_comb begin
        n_e1_carry.kind  = r_m1_side[LAST].kind;
        n_e1_carry.izero = r_m1_side[LAST].izero;
        n_e1_carry.tir   = 1'b0;
        n_e1_carry.n     = r_m1_side[LAST].n;
        n_e1_carry.kterm = m_rc;
        for (int i = 0; i < 3; i++) begin
            n_e1_carry.rv[i]   = m_rv[i];
            n_e1_carry.refl[i] = sat24(rrv_pkg::t_fx'($signed(r_m1_side[LAST].v[i]))
                                       - m_rf[i]);
        end
    end

    // ---------------- second multiplier: r^2 * (1 - cos_i^2)
    rrv_pkg::t_fx    m_ra;
    logic [LAST:0]   r_m2_valid;
    rrv_pkg::t_carry r_m2_carry [rrv_pkg::MUL_LAT];

    rrv_mul u_mul_ra (.i_clk(i_clk), .i_en(en), .i_a(r_e1_r2), .i_b(r_e1_a), .o_p(m_ra));

    // ---------------- E2: cos_t^2, total internal reflection
    logic                       r_e2_valid;
    rrv_pkg::t_carry            r_e2_carry;
    rrv_pkg::t_carry            n_e2_carry;
    logic [rrv_pkg::SAT_W-1:0]  r_e2_t2;
    rrv_pkg::t_fx               t2_raw;
    rrv_pkg::t_fx               t2_sat;
    logic                       t2_neg;

    always_comb begin
        t2_raw = rrv_pkg::ONE_FX - m_ra;
        t2_neg = t2_raw[rrv_pkg::FX_W-1];
        t2_sat = (t2_raw > rrv_pkg::SAT_LIM) ? rrv_pkg::SAT_LIM : t2_raw;
        n_e2_carry     = r_m2_carry[LAST];
        n_e2_carry.tir = r_m2_carry[LAST].kind && (r_m2_carry[LAST].izero || t2_neg);
    end

    // ---------------- square-root row
    rrv_pkg::t_sqrt sq_w [rrv_pkg::ROOT_W+1];
    logic           sq_v [rrv_pkg::ROOT_W+1];

    always_comb begin
        sq_w[0].rad  = rrv_pkg::RAD_W'(r_e2_t2) << rrv_pkg::FRAC_BITS;
        sq_w[0].rem  = '0;
        sq_w[0].root = '0;
        sq_w[0].side = r_e2_carry;
        sq_v[0]      = r_e2_valid;
    end

    for (genvar s = 0; s < rrv_pkg::ROOT_W; s++) begin : g_sqrt
        rrv_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[s]),
            .i_word  (sq_w[s]),
            .o_valid (sq_v[s+1]),
            .o_word  (sq_w[s+1])
        );
    end

    // ---------------- E3: k = r*cos_i - sqrt(cos_t^2)
    logic            r_e3_valid;
    rrv_pkg::t_carry r_e3_carry;
    rrv_pkg::t_carry n_e3_carry;

    always_comb begin
        n_e3_carry       = sq_w[rrv_pkg::ROOT_W].side;
        n_e3_carry.kterm = sq_w[rrv_pkg::ROOT_W].side.kterm
                         - rrv_pkg::t_fx'(sq_w[rrv_pkg::ROOT_W].root);
    end

    // ---------------- third multiplier group: k * norm
    rrv_pkg::t_fx    m_kn [3];
    logic [LAST:0]   r_m3_valid;
    rrv_pkg::t_carry r_m3_carry [rrv_pkg::MUL_LAT];

    for (genvar c = 0; c < 3; c++) begin : g_m3
        rrv_mul u_mul_kn (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_e3_carry.kterm),
            .i_b   (rrv_pkg::t_fx'($signed(r_e3_carry.n[c]))),
            .o_p   (m_kn[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= '0;
            r_e1_valid <= 1'b0;
            r_m2_valid <= '0;
            r_e2_valid <= 1'b0;
            r_e3_valid <= 1'b0;
            r_m3_valid <= '0;
        end else if (en) begin
            r_m1_valid <= {r_m1_valid[LAST-1:0], r_d3_valid};
            r_e1_valid <= r_m1_valid[LAST];
            r_m2_valid <= {r_m2_valid[LAST-1:0], r_e1_valid};
            r_e2_valid <= r_m2_valid[LAST];
            r_e3_valid <= sq_v[rrv_pkg::ROOT_W];
            r_m3_valid <= {r_m3_valid[LAST-1:0], r_e3_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // advance the side delay lines alongside the multipliers
            r_m1_side[0]  <= r_d3_side;
            r_m2_carry[0] <= r_e1_carry;
            r_m3_carry[0] <= r_e3_carry;
            for (int k = 1; k < rrv_pkg::MUL_LAT; k++) begin
                r_m1_side[k]  <= r_m1_side[k-1];
                r_m2_carry[k] <= r_m2_carry[k-1];
                r_m3_carry[k] <= r_m3_carry[k-1];
            end

            r_e1_carry <= n_e1_carry;
            r_e1_r2    <= m_r2;
            r_e1_a     <= rrv_pkg::ONE_FX - m_cc;

            r_e2_carry <= n_e2_carry;
            r_e2_t2    <= t2_neg ? '0 : t2_sat[rrv_pkg::SAT_W-1:0];

            r_e3_carry <= n_e3_carry;
        end
    end

    // ---------------- result select and output register
    rrv_pkg::t_vec n_res;
    rrv_pkg::t_vec r_out_vec;
    logic          r_out_tir;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          last_valid;

    assign last_valid = r_m3_valid[LAST];

    // Hold everything only when the output is full, not drained, and a word is waiting
    assign en = !(r_out_valid && !i_out_ready && last_valid);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_m3_carry[LAST].tir) begin
                n_res[i] = '0;
            end else if (r_m3_carry[LAST].kind) begin
                n_res[i] = sat24(r_m3_carry[LAST].rv[i] + m_kn[i]);
            end else begin
                n_res[i] = r_m3_carry[LAST].refl[i];
            end
        end
        if (en && last_valid) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && last_valid) begin
            r_out_vec <= n_res;
            r_out_tir <= r_m3_carry[LAST].tir;
        end
    end

    assign o_in_ready       = en;
    assign o_out_valid      = r_out_valid;
    assign o_out_x          = r_out_vec[0];
    assign o_out_y          = r_out_vec[1];
    assign o_out_z          = r_out_vec[2];
    assign o_total_internal = r_out_tir;

    // ---------------- checks
    a_tir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_total_internal |-> o_out_x == 0 && o_out_y == 0 && o_out_z == 0)
        else $error("total internal reflection with nonzero vector");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready && last_valid |-> !o_in_ready)
        else $error("word accepted while pipeline is held");

    a_tir_refract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e2_valid && r_e2_carry.tir |-> r_e2_carry.kind)
        else $error("total internal reflection flagged on a reflect word");

endmodule
